// ----- rtl/core/ftcst_pkg.sv -----
// ----------------------------------------------------------------------------
// ftcst_pkg
// Shared types, constants and the byte-wide CRC step for the flow seen-table.
// ----------------------------------------------------------------------------
package ftcst_pkg;

  localparam logic [31:0] CrcPoly    = 32'h0000_1101;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam int          TupleBytes = 14;
  localparam int          TupleBits  = TupleBytes * 8;
  localparam int          KeyBits    = 32;

  typedef enum logic [3:0] {
    S_CLR,    // fill count clearing pass after reset
    S_IDLE,
    S_CRC,    // one tuple byte per cycle
    S_MOD,    // one key bit per cycle into the remainder
    S_FRD,    // fill count read issued
    S_FILL,   // fill count returned
    S_KRD,    // key read issued for current way
    S_KCMP,   // key returned, compare
    S_UPD,    // insert or flag
    S_DONE    // hand over to output register
  } state_e;

  // MSB-first CRC over one byte
  function automatic logic [31:0] crc_byte(logic [31:0] r, logic [7:0] b);
    logic [31:0] c;
    c = r ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/flow_tuple_crc_hash_seen_table.sv -----
// ----------------------------------------------------------------------------
// flow_tuple_crc_hash_seen_table
// Hashes a flow tuple to a CRC key and looks it up in a bucketed key store.
// ----------------------------------------------------------------------------
// Lookup: the way scan covers the bucket's fill count F (0..WAYS); a hit ends
//   the way scan early.
// Throughput: one item at a time, the next transfer taken the cycle after the
//   result enters the output register; set by the byte-serial CRC, the
//   bit-serial modulo and the way reads. Reset: asynchronous, active low; a
//   clearing pass zeroes the fill counts, in_stall_o held high.
module flow_tuple_crc_hash_seen_table #(
  parameter int BUCKETS = 255,
  parameter int WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  protocol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        seen_o,
  output logic        bucket_full_o,
  output logic [31:0] flow_key_o,
  output logic [7:0]  bucket_index_o
);
  import ftcst_pkg::*;

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW    = $clog2(BUCKETS) + 1;
  localparam int DEPTH = BUCKETS * WAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(WAYS + 1);

  localparam logic [RW:0] BktLim   = (RW + 1)'(BUCKETS);
  localparam logic [BW-1:0] BktLast = BW'(BUCKETS - 1);
  localparam logic [FW-1:0] WaysF  = FW'(WAYS);
  localparam logic [4:0] CrcLast   = 5'(TupleBytes - 1);
  localparam logic [4:0] ModLast   = 5'(KeyBits - 1);

  state_e state_q, state_d;

  logic [TupleBits-1:0] tup_q, tup_d;
  logic [31:0]          key_q, key_d;
  logic [31:0]          ksh_q, ksh_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [BW-1:0]        clr_q, clr_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [FW-1:0]        way_q, way_d;
  logic                 hit_q, hit_d;
  logic                 full_q, full_d;

  logic                 out_valid_q, out_valid_d;
  logic                 seen_q, seen_d;
  logic                 bfull_q, bfull_d;
  logic [31:0]          okey_q, okey_d;
  logic [BW-1:0]        obkt_q, obkt_d;

  logic [31:0]   key_mem [DEPTH];
  logic [FW-1:0] fill_mem [BUCKETS];
  logic [31:0]   key_rd_q;
  logic [FW-1:0] fill_rd_q;

  logic          key_we, key_re, fill_we, fill_re;
  logic [AW-1:0] key_addr;
  logic [BW-1:0] fill_waddr;
  logic [FW-1:0] fill_wdata;
  logic [FW-1:0] addr_way;

  logic [BW-1:0] bkt;
  logic [RW:0]   rem_x;
  logic [FW-1:0] fill_clip;
  logic          accept, load_out;

  assign bkt       = rem_q[BW-1:0];
  assign rem_x     = {rem_q, ksh_q[31]};
  assign fill_clip = (fill_rd_q > WaysF) ? WaysF : fill_rd_q;
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign addr_way  = (state_q == S_UPD) ? fill_q : way_q;
  assign key_addr  = AW'(32'(bkt) * WAYS + 32'(addr_way));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == BktLast) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_CRC;
      S_CRC:  if (cnt_q == CrcLast) state_d = S_MOD;
      S_MOD:  if (cnt_q == ModLast) state_d = S_FRD;
      S_FRD:  state_d = S_FILL;
      S_FILL: state_d = (fill_clip == '0) ? S_UPD : S_KRD;
      S_KRD:  state_d = S_KCMP;
      S_KCMP: begin
        if (key_rd_q == key_q || (way_q + 1'b1) == fill_q) state_d = S_UPD;
        else state_d = S_KRD;
      end
      S_UPD:  state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    tup_d      = tup_q;
    key_d      = key_q;
    ksh_d      = ksh_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    fill_d     = fill_q;
    way_d      = way_q;
    hit_d      = hit_q;
    full_d     = full_q;
    key_we     = 1'b0;
    key_re     = 1'b0;
    fill_we    = 1'b0;
    fill_re    = 1'b0;
    fill_waddr = bkt;
    fill_wdata = fill_q + 1'b1;
    in_stall_o = (state_q != S_IDLE);

    case (state_q)
      S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        clr_d      = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          tup_d = {src_port_i[7:0], src_port_i[15:8], dst_port_i[7:0], dst_port_i[15:8],
                   src_ip_i, dst_ip_i, protocol_i, 8'h00};
          key_d = CrcInit;
          cnt_d = '0;
          hit_d = 1'b0;
          full_d = 1'b0;
        end
      end
      S_CRC: begin
        key_d = crc_byte(key_q, tup_q[TupleBits-1 -: 8]);
        tup_d = tup_q << 8;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CrcLast) begin
          ksh_d = key_d;
          rem_d = '0;
          cnt_d = '0;
        end
      end
      S_MOD: begin
        // restoring remainder, key MSB first
        rem_d = (rem_x >= BktLim) ? RW'(rem_x - BktLim) : RW'(rem_x);
        ksh_d = ksh_q << 1;
        cnt_d = cnt_q + 1'b1;
      end
      S_FRD: fill_re = 1'b1;
      S_FILL: begin
        fill_d = fill_clip;
        way_d  = '0;
      end
      S_KRD: key_re = 1'b1;
      S_KCMP: begin
        if (key_rd_q == key_q) hit_d = 1'b1;
        way_d = way_q + 1'b1;
      end
      S_UPD: begin
        if (!hit_q) begin
          if (fill_q >= WaysF) begin
            full_d = 1'b1;
          end else begin
            key_we  = 1'b1;
            fill_we = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    seen_d      = seen_q;
    bfull_d     = bfull_q;
    okey_d      = okey_q;
    obkt_d      = obkt_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      seen_d      = hit_q;
      bfull_d     = full_q;
      okey_d      = key_q;
      obkt_d      = bkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tup_q   <= tup_d;
    key_q   <= key_d;
    ksh_q   <= ksh_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    fill_q  <= fill_d;
    way_q   <= way_d;
    hit_q   <= hit_d;
    full_q  <= full_d;
    seen_q  <= seen_d;
    bfull_q <= bfull_d;
    okey_q  <= okey_d;
    obkt_q  <= obkt_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_addr] <= key_q;
    if (key_re) key_rd_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rd_q <= fill_mem[bkt];
  end

  assign out_valid_o    = out_valid_q;
  assign seen_o         = seen_q;
  assign bucket_full_o  = bfull_q;
  assign flow_key_o     = okey_q;
  assign bucket_index_o = 8'(obkt_q);

endmodule

// ----- rtl/core/ftcst_checker.sv -----
// ----------------------------------------------------------------------------
// ftcst_checker
// Port-level checks for the flow seen-table, bound to the top level.
// ----------------------------------------------------------------------------
module ftcst_checker #(
  parameter int BUCKETS = 255
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        seen_o,
  input logic        bucket_full_o,
  input logic [31:0] flow_key_o,
  input logic [7:0]  bucket_index_o
);

  // a stalled result holds its key
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(flow_key_o)))
    else $error("result dropped or changed while stalled");

  // seen and full are exclusive
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(seen_o && bucket_full_o))
    else $error("seen and bucket_full both set");

  // bucket number stays below the bucket count
  a_bkt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((BUCKETS > 256) || (32'(bucket_index_o) < BUCKETS)))
    else $error("bucket_index out of range");

  // one item at a time: a transfer in blocks the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

endmodule

bind flow_tuple_crc_hash_seen_table ftcst_checker #(.BUCKETS(BUCKETS)) u_ftcst_checker (.*);

// ----- tb/flow_tuple_crc_hash_seen_table_test.sv -----
// ----------------------------------------------------------------------------
// flow_tuple_crc_hash_seen_table_test
// Drives flow tuples through the seen-table and checks every lookup result
// against an in-bench table model (CRC key, bucket, seen and overflow flags).
// Directed corners first, then random traffic biased to repeats and to a few
// hot buckets so that buckets fill up and overflow.
// ----------------------------------------------------------------------------
module flow_tuple_crc_hash_seen_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NumBuckets  = 255;
  localparam int          NumWays     = 4;
  localparam logic [31:0] GenPoly     = 32'h0000_1101;
  localparam logic [31:0] SeedValue   = 32'hFFFF_FFFF;
  localparam int          RandomFlows = 850;
  localparam int          HotCount    = 6;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } tuple_t;

  typedef struct packed {
    logic        seen;
    logic        bucket_full;
    logic [31:0] flow_key;
    logic [7:0]  bucket_index;
  } lookup_t;

  class flow_lookup_board;
    logic [31:0] stored_keys [NumBuckets][NumWays];
    int unsigned ways_used [NumBuckets];
    lookup_t     expected_lookups [$];
    int unsigned mismatches;

    function new();
      foreach (ways_used[b]) ways_used[b] = 0;
      mismatches = 0;
    endfunction

    // bitwise MSB-first CRC over the packed 14-byte tuple
    static function logic [31:0] key_of(tuple_t t);
      logic [111:0] stream;
      logic [31:0]  crc;
      logic         feedback;
      stream = {t.src_port[7:0], t.src_port[15:8], t.dst_port[7:0], t.dst_port[15:8],
                t.src_ip, t.dst_ip, t.protocol, 8'h00};
      crc = SeedValue;
      for (int i = 111; i >= 0; i--) begin
        feedback = crc[31] ^ stream[i];
        crc = crc << 1;
        if (feedback) crc = crc ^ GenPoly;
      end
      return crc;
    endfunction

    static function int unsigned bucket_of(logic [31:0] k);
      return k % 32'(NumBuckets);
    endfunction

    function void note_tuple(tuple_t t);
      lookup_t     exp_l;
      int unsigned b;
      exp_l.flow_key     = key_of(t);
      b                  = bucket_of(exp_l.flow_key);
      exp_l.bucket_index = 8'(b);
      exp_l.seen         = 1'b0;
      exp_l.bucket_full  = 1'b0;
      for (int w = 0; w < ways_used[b]; w++) begin
        if (stored_keys[b][w] == exp_l.flow_key) exp_l.seen = 1'b1;
      end
      if (!exp_l.seen) begin
        if (ways_used[b] >= NumWays) begin
          exp_l.bucket_full = 1'b1;
        end else begin
          stored_keys[b][ways_used[b]] = exp_l.flow_key;
          ways_used[b]++;
        end
      end
      expected_lookups.push_back(exp_l);
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t exp_l;
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result, got key %h bucket %0d seen %0d full %0d",
                 $time, got.flow_key, got.bucket_index, got.seen, got.bucket_full);
        mismatches++;
        return;
      end
      exp_l = expected_lookups.pop_front();
      if (got.seen !== exp_l.seen) begin
        $display("%0t: seen expected %0d got %0d", $time, exp_l.seen, got.seen);
        mismatches++;
      end
      if (got.bucket_full !== exp_l.bucket_full) begin
        $display("%0t: bucket_full expected %0d got %0d", $time, exp_l.bucket_full,
                 got.bucket_full);
        mismatches++;
      end
      if (got.flow_key !== exp_l.flow_key) begin
        $display("%0t: flow_key expected %h got %h", $time, exp_l.flow_key, got.flow_key);
        mismatches++;
      end
      if (got.bucket_index !== exp_l.bucket_index) begin
        $display("%0t: bucket_index expected %0d got %0d", $time, exp_l.bucket_index,
                 got.bucket_index);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] src_ip_i;
  logic [15:0] src_port_i;
  logic [31:0] dst_ip_i;
  logic [15:0] dst_port_i;
  logic [7:0]  protocol_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        seen_o;
  logic        bucket_full_o;
  logic [31:0] flow_key_o;
  logic [7:0]  bucket_index_o;

  flow_lookup_board board = new();
  tuple_t           warmup_tuples [$];
  tuple_t           sent_tuples [$];
  int unsigned      offered = 0;

  flow_tuple_crc_hash_seen_table #(
    .BUCKETS(NumBuckets),
    .WAYS   (NumWays)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .src_ip_i      (src_ip_i),
    .src_port_i    (src_port_i),
    .dst_ip_i      (dst_ip_i),
    .dst_port_i    (dst_port_i),
    .protocol_i    (protocol_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seen_o        (seen_o),
    .bucket_full_o (bucket_full_o),
    .flow_key_o    (flow_key_o),
    .bucket_index_o(bucket_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // transfer monitor: values seen here are those before the edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_tuple({src_ip_i, src_port_i, dst_ip_i, dst_port_i, protocol_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_lookup({seen_o, bucket_full_o, flow_key_o, bucket_index_o});
    end
  end

  function automatic tuple_t random_tuple();
    tuple_t t;
    t.src_ip   = $urandom;
    t.src_port = 16'($urandom_range(0, 65535));
    t.dst_ip   = $urandom;
    t.dst_port = 16'($urandom_range(0, 65535));
    t.protocol = 8'($urandom_range(0, 255));
    // pull the odd field to an extreme
    case ($urandom_range(0, 15))
      0: t.src_ip   = '0;
      1: t.src_ip   = '1;
      2: t.src_port = '0;
      3: t.src_port = '1;
      4: t.dst_ip   = '0;
      5: t.dst_ip   = '1;
      6: t.dst_port = '0;
      7: t.dst_port = '1;
      8: t.protocol = '0;
      9: t.protocol = '1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic tuple_t tuple_for_bucket(int unsigned b);
    tuple_t t;
    do t = random_tuple();
    while (flow_lookup_board::bucket_of(flow_lookup_board::key_of(t)) != b);
    return t;
  endfunction

  // one more distinct key than the bucket holds, so the last one overflows
  function automatic void add_overflow_burst(int unsigned b);
    logic [31:0] keys [$];
    tuple_t      t;
    for (int k = 0; k <= NumWays; k++) begin
      do t = tuple_for_bucket(b);
      while (flow_lookup_board::key_of(t) inside {keys});
      keys.push_back(flow_lookup_board::key_of(t));
      warmup_tuples.push_back(t);
    end
  endfunction

  task automatic offer_tuple(input tuple_t t);
    int unsigned gap;
    gap = ((offered / 60) % 3 == 2) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_ip_i   <= t.src_ip;
    src_port_i <= t.src_port;
    dst_ip_i   <= t.dst_ip;
    dst_port_i <= t.dst_port;
    protocol_i <= t.protocol;
    do @(posedge clk_i);
    while (in_stall_o);
    offered++;
    sent_tuples.push_back(t);
  endtask

  // result side, with one long hold-off to back the block up
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken == 400) hold = 300;
      else if ((taken / 40) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i);
      while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    tuple_t      t;
    tuple_t      zero_t;
    int unsigned hot [HotCount];
    int unsigned pick;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    src_ip_i   <= '0;
    src_port_i <= '0;
    dst_ip_i   <= '0;
    dst_port_i <= '0;
    protocol_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, with repeats of the all-zero and all-one tuples
    zero_t = '0;
    warmup_tuples.push_back(zero_t);
    warmup_tuples.push_back('1);
    warmup_tuples.push_back(zero_t);
    warmup_tuples.push_back('1);
    t = zero_t; t.src_ip   = '1; warmup_tuples.push_back(t);
    t = zero_t; t.src_port = '1; warmup_tuples.push_back(t);
    t = zero_t; t.dst_ip   = '1; warmup_tuples.push_back(t);
    t = zero_t; t.dst_port = '1; warmup_tuples.push_back(t);
    t = zero_t; t.protocol = '1; warmup_tuples.push_back(t);
    // fill the top bucket, overflow it, then hit a stored key and overflow again
    add_overflow_burst(NumBuckets - 1);
    warmup_tuples.push_back(warmup_tuples[warmup_tuples.size() - NumWays - 1]);
    warmup_tuples.push_back(warmup_tuples[warmup_tuples.size() - 2]);
    add_overflow_burst(0);
    warmup_tuples.push_back(warmup_tuples[warmup_tuples.size() - 1]);
    foreach (warmup_tuples[i]) offer_tuple(warmup_tuples[i]);

    foreach (hot[h]) hot[h] = $urandom_range(0, NumBuckets - 1);
    for (int n = 0; n < RandomFlows; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        t = random_tuple();
      end else if (pick < 70) begin
        t = sent_tuples[$urandom_range(0, sent_tuples.size() - 1)];
      end else if (pick < 95) begin
        t = tuple_for_bucket(hot[$urandom_range(0, HotCount - 1)]);
      end else begin
        // near miss: a known flow with one bit changed
        t = sent_tuples[$urandom_range(0, sent_tuples.size() - 1)];
        case ($urandom_range(0, 4))
          0: t.src_ip                          = t.src_ip ^ (32'h1 << $urandom_range(0, 31));
          1: t.src_port                        = t.src_port ^ (16'h1 << $urandom_range(0, 15));
          2: t.dst_ip                          = t.dst_ip ^ (32'h1 << $urandom_range(0, 31));
          3: t.dst_port                        = t.dst_port ^ (16'h1 << $urandom_range(0, 15));
          default: t.protocol                  = t.protocol ^ (8'h1 << $urandom_range(0, 7));
        endcase
      end
      offer_tuple(t);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
